// File: hdl/hcf_pkg.sv
// Shared types, register codes and saturating Q16.16 helpers for the
// HLLE conduction flux block. No dependencies.
`default_nettype none

package hcf_pkg;

   localparam int DIV_STEPS = 32;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam logic [30:0] MAX_SPEED_RESET = 31'd65536;
   localparam logic [15:0] TINY_RESET      = 16'd0;

   typedef enum logic {
      CSR_MAX_SPEED = 1'b0,
      CSR_TINY      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         direction;
      logic signed [31:0] energy_left;
      logic signed [31:0] energy_right;
      logic signed [31:0] flux_left;
      logic signed [31:0] flux_right;
      logic signed [31:0] temp_left;
      logic signed [31:0] temp_right;
      logic [30:0]        density_left;
      logic [30:0]        density_right;
      logic signed [31:0] speed_left;
      logic signed [31:0] speed_right;
      logic               last_interface;
   } req_type;

   typedef struct packed {
      logic signed [31:0] energy_flux;
      logic signed [31:0] flux_x;
      logic signed [31:0] flux_y;
      logic signed [31:0] flux_z;
      logic               last_out;
   } rsp_type;

   // Saturate a 33-bit value to 32 bits.
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? Q_MIN : Q_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Saturate a 64-bit value to 32 bits.
   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v[63] && !(&v[62:31])) begin
         r = Q_MIN;
      end else if (!v[63] && (|v[62:31])) begin
         r = Q_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Rescale a raw product by 2^-16 (floor) and saturate.
   function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
      return sat64(p >>> 16);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat33(33'(a) + 33'(b));
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat33(33'(a) - 33'(b));
   endfunction

endpackage

`default_nettype wire

// File: hdl/hcf_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on hcf_pkg for the payload types.
`default_nettype none

interface hcf_req_if;
   import hcf_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hcf_rsp_if;
   import hcf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/hcf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The starting remainder must be below the divisor. Uses no package.
`default_nettype none

module hcf_div #(
   parameter int DW = 32,
   parameter int QW = 32
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] rem_i,
   input  wire logic [QW-1:0] num_i,
   input  wire logic [DW-1:0] den_i,
   output logic      [QW-1:0] quo_o
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] num_ff [QW];
   logic [DW-1:0] den_ff [QW];

   // The numerator shifts out at the top while quotient bits shift in below.
   function automatic logic [DW+QW-1:0] step(input logic [DW-1:0] rem,
                                             input logic [QW-1:0] num,
                                             input logic [DW-1:0] den);
      logic [DW:0] trial;
      logic [DW:0] delta;
      logic        ge;
      trial = {rem, num[QW-1]};
      delta = trial - {1'b0, den};
      ge    = trial >= {1'b0, den};
      return {(ge ? delta[DW-1:0] : trial[DW-1:0]), num[QW-2:0], ge};
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         {rem_ff[0], num_ff[0]} <= step(rem_i, num_i, den_i);
         den_ff[0] <= den_i;
         for (int k = 1; k < QW; k++) begin
            {rem_ff[k], num_ff[k]} <= step(rem_ff[k-1], num_ff[k-1], den_ff[k-1]);
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo_o = num_ff[QW-1];

endmodule

`default_nettype wire

// File: hdl/hlle_conduction_flux.sv
// HLLE conduction flux: one cell interface in, one flux set out.
// The five 32-step divider pipelines set most of the pipeline depth between a
// request transfer and the response being valid.
// Throughput is one interface per cycle; the whole pipeline holds while a
// response waits untaken. Synchronous reset clears the valid bits and loads
// max_speed = 1.0 and tiny_threshold = 0.
`default_nettype none

module hlle_conduction_flux (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hcf_req_if.sink                    req_chan,
   hcf_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_en,
   input  wire hcf_pkg::csr_index_type csr_index,
   input  wire logic [30:0]           csr_wdata
);
   import hcf_pkg::*;

   localparam int V_S5  = 4;
   localparam int V_S6  = V_S5 + 1 + DIV_STEPS;
   localparam int NSTG  = V_S6 + 6;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] el, er, fxl, fxr, tl, tr, sl, sr, meanv;
      logic [30:0] rl, rr, meanr;
   } s2_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] el, er, fxl, fxr, bm, bp;
      logic [30:0] rl, rr, meanr;
      logic signed [63:0] pv_fl, pv_fr, pv_tl, pv_tr;
   } s3_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic [30:0] rl, rr, meanr;
      logic signed [31:0] vm_fl, vm_fr, vm_tl, vm_tr, wsum;
      logic signed [63:0] pa_el, pa_er, pc_l, pc_r;
      logic [31:0] wdiff; logic wok;
   } s4_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic [30:0] rl, rr, meanr;
      logic signed [31:0] vm_fl, vm_fr, vm_tl, vm_tr, wsum, a_el, a_er, c_l, c_r;
      logic [31:0] wdiff; logic wok;
   } s5_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] a_el, a_er, vm_fl, vm_fr, vm_tl, vm_tr;
      logic ratl_ov, ratr_ov, cl_ov, cr_ov, cl_neg, cr_neg, w_neg, wok;
   } side_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] a_el, a_er, vm_fl, vm_fr, vm_tl, vm_tr, ratl, ratr, cdl, cdr;
      logic signed [16:0] w;
   } s6_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] vm_fl, vm_fr, fl_c, fr_c;
      logic signed [63:0] pe_l, pe_r;
      logic signed [16:0] w;
   } s7_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] fl_e, fr_e, fl_c, fr_c;
      logic signed [16:0] w;
   } s8_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] he, de, hc, dc;
      logic signed [16:0] w;
   } s9_type;

   typedef struct packed {
      logic [1:0] dir; logic last;
      logic signed [31:0] he, hc;
      logic signed [48:0] pe, pc;
   } s10_type;

   logic [30:0] max_speed_ff;
   logic [15:0] tiny_ff;
   logic [NSTG-1:0] valid_ff, valid_in;
   logic en;

   req_type  s1_ff;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   s5_type   s5_ff, s5_in;
   side_type side_ff [DIV_STEPS];
   side_type side_in;
   s6_type   s6_ff, s6_in;
   s7_type   s7_ff, s7_in;
   s8_type   s8_ff, s8_in;
   s9_type   s9_ff, s9_in;
   s10_type  s10_ff, s10_in;
   rsp_type  out_ff, out_in;

   logic [31:0] mag_cl, mag_cr, mag_w;
   logic [31:0] q_ratl, q_ratr, q_cl, q_cr, q_w;
   logic signed [32:0] sum33_e, sum33_c, sum33_v;
   logic [31:0] sum_r;
   logic signed [32:0] wsum33;
   logic signed [63:0] pe64, pc64;
   side_type side_out;

   // The pipeline holds as a whole while the output register is full and untaken.
   assign en             = !valid_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = valid_ff[NSTG-1];
   assign rsp_chan.data  = out_ff;
   assign valid_in       = {valid_ff[NSTG-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= MAX_SPEED_RESET;
         tiny_ff      <= TINY_RESET;
         valid_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAX_SPEED: max_speed_ff <= csr_wdata;
               CSR_TINY:      tiny_ff      <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (en) begin
            valid_ff <= valid_in;
         end
      end
   end

   // Front end: means, wave speeds and the products that need no division.
   always_comb begin
      s2_in.dir   = s1_ff.direction;
      s2_in.last  = s1_ff.last_interface;
      s2_in.el    = s1_ff.energy_left;
      s2_in.er    = s1_ff.energy_right;
      s2_in.fxl   = s1_ff.flux_left;
      s2_in.fxr   = s1_ff.flux_right;
      s2_in.tl    = s1_ff.temp_left;
      s2_in.tr    = s1_ff.temp_right;
      s2_in.sl    = s1_ff.speed_left;
      s2_in.sr    = s1_ff.speed_right;
      // A zero density counts as one LSB so that no density or mean-density divisor is zero.
      s2_in.rl    = (s1_ff.density_left == '0) ? 31'd1 : s1_ff.density_left;
      s2_in.rr    = (s1_ff.density_right == '0) ? 31'd1 : s1_ff.density_right;
      sum33_v     = 33'(s1_ff.speed_left) + 33'(s1_ff.speed_right);
      s2_in.meanv = sum33_v[32:1];
      sum_r       = {1'b0, s2_in.rl} + {1'b0, s2_in.rr};
      s2_in.meanr = sum_r[31:1];

      s3_in.dir   = s2_ff.dir;
      s3_in.last  = s2_ff.last;
      s3_in.el    = s2_ff.el;
      s3_in.er    = s2_ff.er;
      s3_in.fxl   = s2_ff.fxl;
      s3_in.fxr   = s2_ff.fxr;
      s3_in.rl    = s2_ff.rl;
      s3_in.rr    = s2_ff.rr;
      s3_in.meanr = s2_ff.meanr;
      s3_in.bm    = (s2_ff.meanv < s2_ff.sl) ? s2_ff.meanv : s2_ff.sl;
      if (s3_in.bm > 32'sd0) begin
         s3_in.bm = 32'sd0;
      end
      s3_in.bp    = (s2_ff.meanv > s2_ff.sr) ? s2_ff.meanv : s2_ff.sr;
      if (s3_in.bp < 32'sd0) begin
         s3_in.bp = 32'sd0;
      end
      s3_in.pv_fl = $signed({1'b0, max_speed_ff}) * s2_ff.fxl;
      s3_in.pv_fr = $signed({1'b0, max_speed_ff}) * s2_ff.fxr;
      s3_in.pv_tl = $signed({1'b0, max_speed_ff}) * s2_ff.tl;
      s3_in.pv_tr = $signed({1'b0, max_speed_ff}) * s2_ff.tr;

      s4_in.dir   = s3_ff.dir;
      s4_in.last  = s3_ff.last;
      s4_in.rl    = s3_ff.rl;
      s4_in.rr    = s3_ff.rr;
      s4_in.meanr = s3_ff.meanr;
      s4_in.vm_fl = qmul(s3_ff.pv_fl);
      s4_in.vm_fr = qmul(s3_ff.pv_fr);
      s4_in.vm_tl = qmul(s3_ff.pv_tl);
      s4_in.vm_tr = qmul(s3_ff.pv_tr);
      s4_in.pa_el = s3_ff.bm * s3_ff.el;
      s4_in.pa_er = s3_ff.bp * s3_ff.er;
      s4_in.pc_l  = s3_ff.bm * s3_ff.fxl;
      s4_in.pc_r  = s3_ff.bp * s3_ff.fxr;
      wsum33      = 33'(s3_ff.bp) + 33'(s3_ff.bm);
      s4_in.wsum  = wsum33[31:0];
      s4_in.wdiff = 32'(33'(s3_ff.bp) - 33'(s3_ff.bm));
      s4_in.wok   = s4_in.wdiff > {16'd0, tiny_ff};

      s5_in.dir   = s4_ff.dir;
      s5_in.last  = s4_ff.last;
      s5_in.rl    = s4_ff.rl;
      s5_in.rr    = s4_ff.rr;
      s5_in.meanr = s4_ff.meanr;
      s5_in.vm_fl = s4_ff.vm_fl;
      s5_in.vm_fr = s4_ff.vm_fr;
      s5_in.vm_tl = s4_ff.vm_tl;
      s5_in.vm_tr = s4_ff.vm_tr;
      s5_in.wsum  = s4_ff.wsum;
      s5_in.wdiff = s4_ff.wdiff;
      s5_in.wok   = s4_ff.wok;
      s5_in.a_el  = qmul(s4_ff.pa_el);
      s5_in.a_er  = qmul(s4_ff.pa_er);
      s5_in.c_l   = qmul(s4_ff.pc_l);
      s5_in.c_r   = qmul(s4_ff.pc_r);
   end

   // Divider set-up. Each quotient that would not fit in 32 bits is flagged
   // here and saturated after the divider, so the divider sees a remainder
   // already below its divisor.
   always_comb begin
      mag_cl = s5_ff.c_l[31] ? 32'(-s5_ff.c_l) : 32'(s5_ff.c_l);
      mag_cr = s5_ff.c_r[31] ? 32'(-s5_ff.c_r) : 32'(s5_ff.c_r);
      mag_w  = s5_ff.wsum[31] ? 32'(-s5_ff.wsum) : 32'(s5_ff.wsum);

      side_in.dir     = s5_ff.dir;
      side_in.last    = s5_ff.last;
      side_in.a_el    = s5_ff.a_el;
      side_in.a_er    = s5_ff.a_er;
      side_in.vm_fl   = s5_ff.vm_fl;
      side_in.vm_fr   = s5_ff.vm_fr;
      side_in.vm_tl   = s5_ff.vm_tl;
      side_in.vm_tr   = s5_ff.vm_tr;
      side_in.ratl_ov = {15'd0, s5_ff.meanr} >= {s5_ff.rl, 15'd0};
      side_in.ratr_ov = {15'd0, s5_ff.meanr} >= {s5_ff.rr, 15'd0};
      side_in.cl_ov   = {15'd0, mag_cl[31:16]} >= s5_ff.meanr;
      side_in.cr_ov   = {15'd0, mag_cr[31:16]} >= s5_ff.meanr;
      side_in.cl_neg  = s5_ff.c_l[31];
      side_in.cr_neg  = s5_ff.c_r[31];
      side_in.w_neg   = s5_ff.wsum[31];
      side_in.wok     = s5_ff.wok;
   end

   hcf_div #(.DW(31), .QW(DIV_STEPS)) u_div_ratl (
      .clock (clock), .en (en),
      .rem_i ({16'd0, s5_ff.meanr[30:16]}), .num_i ({s5_ff.meanr[15:0], 16'd0}),
      .den_i (s5_ff.rl), .quo_o (q_ratl)
   );

   hcf_div #(.DW(31), .QW(DIV_STEPS)) u_div_ratr (
      .clock (clock), .en (en),
      .rem_i ({16'd0, s5_ff.meanr[30:16]}), .num_i ({s5_ff.meanr[15:0], 16'd0}),
      .den_i (s5_ff.rr), .quo_o (q_ratr)
   );

   hcf_div #(.DW(31), .QW(DIV_STEPS)) u_div_cl (
      .clock (clock), .en (en),
      .rem_i ({15'd0, mag_cl[31:16]}), .num_i ({mag_cl[15:0], 16'd0}),
      .den_i (s5_ff.meanr), .quo_o (q_cl)
   );

   hcf_div #(.DW(31), .QW(DIV_STEPS)) u_div_cr (
      .clock (clock), .en (en),
      .rem_i ({15'd0, mag_cr[31:16]}), .num_i ({mag_cr[15:0], 16'd0}),
      .den_i (s5_ff.meanr), .quo_o (q_cr)
   );

   hcf_div #(.DW(32), .QW(DIV_STEPS)) u_div_w (
      .clock (clock), .en (en),
      .rem_i ({17'd0, mag_w[31:17]}), .num_i ({mag_w[16:0], 15'd0}),
      .den_i (s5_ff.wdiff), .quo_o (q_w)
   );

   assign side_out = side_ff[DIV_STEPS-1];

   // Back end: saturate quotients, finish the one-sided fluxes, then average.
   always_comb begin
      s6_in.dir   = side_out.dir;
      s6_in.last  = side_out.last;
      s6_in.a_el  = side_out.a_el;
      s6_in.a_er  = side_out.a_er;
      s6_in.vm_fl = side_out.vm_fl;
      s6_in.vm_fr = side_out.vm_fr;
      s6_in.vm_tl = side_out.vm_tl;
      s6_in.vm_tr = side_out.vm_tr;
      s6_in.ratl  = side_out.ratl_ov ? Q_MAX : sat33(33'(q_ratl));
      s6_in.ratr  = side_out.ratr_ov ? Q_MAX : sat33(33'(q_ratr));
      if (side_out.cl_ov) begin
         s6_in.cdl = side_out.cl_neg ? Q_MIN : Q_MAX;
      end else begin
         s6_in.cdl = sat33(side_out.cl_neg ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl}));
      end
      if (side_out.cr_ov) begin
         s6_in.cdr = side_out.cr_neg ? Q_MIN : Q_MAX;
      end else begin
         s6_in.cdr = sat33(side_out.cr_neg ? -$signed({1'b0, q_cr}) : $signed({1'b0, q_cr}));
      end
      // The weight magnitude never exceeds one half in Q16.16.
      if (!side_out.wok) begin
         s6_in.w = 17'sd0;
      end else if (side_out.w_neg) begin
         s6_in.w = -$signed({1'b0, q_w[15:0]});
      end else begin
         s6_in.w = $signed({1'b0, q_w[15:0]});
      end

      s7_in.dir   = s6_ff.dir;
      s7_in.last  = s6_ff.last;
      s7_in.vm_fl = s6_ff.vm_fl;
      s7_in.vm_fr = s6_ff.vm_fr;
      s7_in.pe_l  = s6_ff.a_el * s6_ff.ratl;
      s7_in.pe_r  = s6_ff.a_er * s6_ff.ratr;
      s7_in.fl_c  = qsub(s6_ff.vm_tl, s6_ff.cdl);
      s7_in.fr_c  = qsub(s6_ff.vm_tr, s6_ff.cdr);
      s7_in.w     = s6_ff.w;

      s8_in.dir   = s7_ff.dir;
      s8_in.last  = s7_ff.last;
      s8_in.fl_e  = qsub(s7_ff.vm_fl, qmul(s7_ff.pe_l));
      s8_in.fr_e  = qsub(s7_ff.vm_fr, qmul(s7_ff.pe_r));
      s8_in.fl_c  = s7_ff.fl_c;
      s8_in.fr_c  = s7_ff.fr_c;
      s8_in.w     = s7_ff.w;

      sum33_e     = 33'(s8_ff.fl_e) + 33'(s8_ff.fr_e);
      sum33_c     = 33'(s8_ff.fl_c) + 33'(s8_ff.fr_c);
      s9_in.dir   = s8_ff.dir;
      s9_in.last  = s8_ff.last;
      s9_in.he    = sum33_e[32:1];
      s9_in.hc    = sum33_c[32:1];
      s9_in.de    = qsub(s8_ff.fl_e, s8_ff.fr_e);
      s9_in.dc    = qsub(s8_ff.fl_c, s8_ff.fr_c);
      s9_in.w     = s8_ff.w;

      s10_in.dir  = s9_ff.dir;
      s10_in.last = s9_ff.last;
      s10_in.he   = s9_ff.he;
      s10_in.hc   = s9_ff.hc;
      s10_in.pe   = s9_ff.de * s9_ff.w;
      s10_in.pc   = s9_ff.dc * s9_ff.w;

      pe64 = 64'(s10_ff.pe);
      pc64 = 64'(s10_ff.pc);
      out_in.energy_flux = qadd(s10_ff.he, qmul(pe64));
      out_in.flux_x      = '0;
      out_in.flux_y      = '0;
      out_in.flux_z      = '0;
      case (s10_ff.dir)
         2'd1:    out_in.flux_x = qadd(s10_ff.hc, qmul(pc64));
         2'd2:    out_in.flux_y = qadd(s10_ff.hc, qmul(pc64));
         2'd3:    out_in.flux_z = qadd(s10_ff.hc, qmul(pc64));
         default: ;
      endcase
      out_in.last_out = s10_ff.last;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= req_chan.data;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         s5_ff      <= s5_in;
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         s6_ff      <= s6_in;
         s7_ff      <= s7_in;
         s8_ff      <= s8_in;
         s9_ff      <= s9_in;
         s10_ff     <= s10_in;
         out_ff     <= out_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[V_S6] |-> (s6_ff.w >= -17'sd32768 && s6_ff.w <= 17'sd32768))
      else $error("HLLE weight outside one half");

   a_weight_divisor: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[V_S5] && s5_ff.wok) |-> (s5_ff.wdiff != 32'd0))
      else $error("weight divider enabled with a zero divisor");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the pipeline is held");
`endif

endmodule

`default_nettype wire
